// ----- hdl/fcfs_schedule_metrics_core_assert.svh -----
// assertion macros used by the checker file
// depends on nothing
`ifndef FCFS_SCHEDULE_METRICS_CORE_ASSERT_SVH
`define FCFS_SCHEDULE_METRICS_CORE_ASSERT_SVH
`define FSM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FSM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- hdl/fsm_pkg.sv -----
// shared types and constants for the fcfs schedule metrics block
// depends on nothing
`default_nettype none
package fsm_pkg;
    localparam int MaxJobs = 16;
    localparam int IdxW    = $clog2(MaxJobs);
    localparam int CntW    = $clog2(MaxJobs + 1);
    localparam int TimeW   = 21;
    localparam int SumW    = 25;
    localparam int AvgW    = 29;
    localparam int DivW    = SumW + 8;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic        last;
    } t_rec;

    typedef enum logic [2:0] {
        ST_LOAD, ST_SHIFT, ST_RUN, ST_DIV, ST_FINAL
    } t_state;
endpackage
`default_nettype wire

// ----- hdl/fcfs_schedule_metrics_core.sv -----
// top level of the fcfs schedule metrics block
// depends on fsm_pkg, fsm_front, fsm_back
//
// slave channel carries process records (id, arrival, burst), tlast closes a set.
// records are held in a two-entry input queue, then inserted into a sorted
// 16-entry store, shifting later-arriving entries up one place at a time.
// once a set closes, one result per job leaves on the master channel, one per
// cycle while the receiver keeps tready high; the final result waits for a
// restoring divider that forms both averages, then carries tlast and
// the averages (8 fraction bits). records beyond 16 only obey their tlast.
// the store takes no record while a set is being emitted; the input queue still fills.
// a stalled receiver holds the output register and the run stops with it.
// reset empties the queue and store and drops any pending result.
`default_nettype none
module fcfs_schedule_metrics_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,  // proc_id, arrival, burst
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_id, out_arrival, out_burst, completion, turnaround, waiting,
    // avg_turnaround, avg_waiting, zero fill
    output logic [167:0]      m_axis_tdata,
    output logic              m_axis_tlast
);
    fsm_pkg::t_rec in_rec, q_rec;
    logic q_valid, q_ready;
    logic [160:0] b_data;

    assign in_rec = '{id: s_axis_tdata[7:0], arrival: s_axis_tdata[23:8],
                      burst: s_axis_tdata[39:24], last: s_axis_tlast};
    assign m_axis_tdata = {7'd0, b_data};

    fsm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_rec(in_rec),
        .o_valid(q_valid), .i_ready(q_ready), .o_rec(q_rec)
    );

    fsm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_rec(q_rec),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(b_data), .o_last(m_axis_tlast)
    );
endmodule
`default_nettype wire

// ----- hdl/fsm_front.sv -----
// front: input skid queue of two records
// depends on fsm_pkg
`default_nettype none
module fsm_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire fsm_pkg::t_rec i_rec,
    output logic              o_valid,
    input  wire logic         i_ready,
    output fsm_pkg::t_rec     o_rec
);
    fsm_pkg::t_rec r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, n_rd;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
        n_rd  = pop ? ~r_rd : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
        end
        if (push) begin
            r_q[r_rd ^ r_cnt[0]] <= i_rec;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/fsm_back.sv -----
// back: sorted insert into job store, fcfs run, averaging divider
// depends on fsm_pkg
`default_nettype none
module fsm_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire fsm_pkg::t_rec i_rec,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [160:0]       o_data,
    output logic               o_last
);
    localparam int IW = fsm_pkg::IdxW;
    localparam int CW = fsm_pkg::CntW;
    localparam int TW = fsm_pkg::TimeW;
    localparam int SW = fsm_pkg::SumW;
    localparam int DW = fsm_pkg::DivW;

    logic [7:0]  r_id  [fsm_pkg::MaxJobs];
    logic [15:0] r_arr [fsm_pkg::MaxJobs];
    logic [15:0] r_bur [fsm_pkg::MaxJobs];

    fsm_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_k, n_k;
    fsm_pkg::t_rec r_hold, n_hold;
    logic [TW-1:0] r_fin, n_fin;
    logic [SW-1:0] r_tsum, n_tsum, r_wsum, n_wsum;
    logic [DW-1:0] r_qt, n_qt, r_qw, n_qw;
    logic [CW:0]   r_rt, n_rt, r_rw, n_rw;
    logic [5:0]    r_dstep, n_dstep;
    logic          r_ov, n_ov;
    logic [160:0]  r_out, n_out;
    logic          r_olast, n_olast;

    logic [IW-1:0] kx, px, pm1;
    logic [TW-1:0] a, b, start, ct, tat, wt;
    logic          out_free;
    logic          wr_shift, wr_ins;
    logic [CW:0]   st_t, st_w;
    logic [CW:0]   dv;

    assign kx  = r_k[IW-1:0];
    assign px  = r_pos[IW-1:0];
    assign pm1 = px - 1'b1;
    assign a   = {5'd0, r_arr[kx]};
    assign b   = {5'd0, r_bur[kx]};
    assign start = (r_fin < a) ? a : r_fin;
    assign ct  = start + b;
    assign tat = ct - a;
    assign wt  = tat - b;
    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_st == fsm_pkg::ST_LOAD);
    assign o_valid  = r_ov;
    assign o_data   = r_out;
    assign o_last   = r_olast;
    assign dv = {1'b0, r_cnt};
    assign st_t = {r_rt[CW-1:0], r_qt[DW-1]};
    assign st_w = {r_rw[CW-1:0], r_qw[DW-1]};

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_pos = r_pos; n_k = r_k; n_hold = r_hold;
        n_fin = r_fin; n_tsum = r_tsum; n_wsum = r_wsum;
        n_qt = r_qt; n_qw = r_qw; n_rt = r_rt; n_rw = r_rw; n_dstep = r_dstep;
        n_ov = r_ov && !i_ready; n_out = r_out; n_olast = r_olast;
        wr_shift = 1'b0; wr_ins = 1'b0;
        unique case (r_st)
            fsm_pkg::ST_LOAD: begin
                if (i_valid) begin
                    n_hold = i_rec;
                    n_pos  = r_cnt;
                    if (r_cnt < CW'(fsm_pkg::MaxJobs)) begin
                        n_st = fsm_pkg::ST_SHIFT;
                    end else if (i_rec.last) begin
                        n_k = '0;
                        n_st = fsm_pkg::ST_RUN;
                    end
                end
            end
            fsm_pkg::ST_SHIFT: begin
                if (r_pos != '0 && r_arr[pm1] > r_hold.arrival) begin
                    wr_shift = 1'b1;
                    n_pos = r_pos - 1'b1;
                end else begin
                    wr_ins = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_k = '0;
                    n_st = r_hold.last ? fsm_pkg::ST_RUN : fsm_pkg::ST_LOAD;
                end
            end
            fsm_pkg::ST_RUN: begin
                if (r_k == r_cnt) begin
                    n_qt = {r_tsum, 8'd0};
                    n_qw = {r_wsum, 8'd0};
                    n_rt = '0; n_rw = '0; n_dstep = '0;
                    n_st = fsm_pkg::ST_DIV;
                end else if (out_free && (r_k + 1'b1 != r_cnt)) begin
                    n_fin = ct;
                    n_tsum = r_tsum + SW'(tat);
                    n_wsum = r_wsum + SW'(wt);
                    n_out = {58'd0, wt, tat, ct, b[15:0], a[15:0], r_id[kx]};
                    n_olast = 1'b0;
                    n_ov = 1'b1;
                    n_k = r_k + 1'b1;
                end else if (out_free && (r_k + 1'b1 == r_cnt)) begin
                    n_fin = ct;
                    n_tsum = r_tsum + SW'(tat);
                    n_wsum = r_wsum + SW'(wt);
                    n_out = {58'd0, wt, tat, ct, b[15:0], a[15:0], r_id[kx]};
                    n_k = r_k + 1'b1;
                end
            end
            fsm_pkg::ST_DIV: begin
                n_qt = {r_qt[DW-2:0], (st_t >= dv)};
                n_qw = {r_qw[DW-2:0], (st_w >= dv)};
                n_rt = (st_t >= dv) ? st_t - dv : st_t;
                n_rw = (st_w >= dv) ? st_w - dv : st_w;
                n_dstep = r_dstep + 1'b1;
                if (r_dstep == 6'(DW - 1)) begin
                    n_st = fsm_pkg::ST_FINAL;
                end
            end
            fsm_pkg::ST_FINAL: begin
                if (out_free) begin
                    n_out[160:103] = {r_qw[fsm_pkg::AvgW-1:0], r_qt[fsm_pkg::AvgW-1:0]};
                    n_olast = 1'b1;
                    n_ov = 1'b1;
                    n_cnt = '0; n_fin = '0; n_tsum = '0; n_wsum = '0;
                    n_st = fsm_pkg::ST_LOAD;
                end
            end
            default: n_st = fsm_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= fsm_pkg::ST_LOAD;
            r_cnt <= '0; r_fin <= '0; r_tsum <= '0; r_wsum <= '0;
            r_ov <= 1'b0; r_k <= '0; r_pos <= '0; r_dstep <= '0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_fin <= n_fin;
            r_tsum <= n_tsum; r_wsum <= n_wsum; r_ov <= n_ov;
            r_k <= n_k; r_pos <= n_pos; r_dstep <= n_dstep;
        end
        r_hold <= n_hold; r_qt <= n_qt; r_qw <= n_qw;
        r_rt <= n_rt; r_rw <= n_rw; r_out <= n_out; r_olast <= n_olast;
        if (wr_shift) begin
            r_id[px]  <= r_id[pm1];
            r_arr[px] <= r_arr[pm1];
            r_bur[px] <= r_bur[pm1];
        end
        if (wr_ins) begin
            r_id[px]  <= r_hold.id;
            r_arr[px] <= r_hold.arrival;
            r_bur[px] <= r_hold.burst;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/fsm_checker.sv -----
// port-level checks for the fcfs schedule metrics block
// depends on fcfs_schedule_metrics_core_assert.svh
`include "fcfs_schedule_metrics_core_assert.svh"
`default_nettype none
module fsm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [167:0] m_axis_tdata,
    input wire logic         m_axis_tlast
);
    logic        stalled;
    logic [15:0] res_arr;
    logic [20:0] res_ct, res_tat;
    logic [57:0] res_avg;
    logic [6:0]  res_pad;

    assign stalled = m_axis_tvalid && !m_axis_tready;
    assign res_arr = m_axis_tdata[23:8];
    assign res_ct  = m_axis_tdata[60:40];
    assign res_tat = m_axis_tdata[81:61];
    assign res_avg = m_axis_tdata[160:103];
    assign res_pad = m_axis_tdata[167:161];

    `FSM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata))
    `FSM_ASSERT_NEXT(a_hold_last, i_clk, i_rst_n, stalled, $stable(m_axis_tlast))
    `FSM_ASSERT_IMPL(a_avg0, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, res_avg == 58'd0)
    `FSM_ASSERT_IMPL(a_pad, i_clk, i_rst_n, m_axis_tvalid, res_pad == 7'd0)
    `FSM_ASSERT_IMPL(a_tat, i_clk, i_rst_n, m_axis_tvalid, res_tat == res_ct - 21'(res_arr))
endmodule
bind fcfs_schedule_metrics_core fsm_checker u_chk (.*);
`default_nettype wire

// ----- verif/tb_fcfs_schedule_metrics_core.sv -----
// testbench for the fcfs schedule metrics block: directed and random process sets
// with a schedule predictor, random idling on both channels and a long receiver stall
// depends on fsm_pkg and fcfs_schedule_metrics_core
`default_nettype none
module tb_fcfs_schedule_metrics_core;
    typedef struct packed {
        logic [28:0] avg_wt;
        logic [28:0] avg_tat;
        logic [20:0] wt;
        logic [20:0] tat;
        logic [20:0] ct;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [7:0]  id;
    } t_metrics;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;  // proc_id, arrival, burst
    logic         s_axis_tlast = 1'b0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // out_id, out_arrival, out_burst, completion, turnaround, waiting,
    // avg_turnaround, avg_waiting, zero fill
    wire  [167:0] m_axis_tdata;
    wire          m_axis_tlast;

    fcfs_schedule_metrics_core u_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
    );

    always #5 i_clk = ~i_clk;

    // schedule predictor state
    logic [7:0]  job_id  [fsm_pkg::MaxJobs];
    logic [15:0] job_arr [fsm_pkg::MaxJobs];
    logic [15:0] job_bur [fsm_pkg::MaxJobs];
    int          job_cnt;

    t_metrics    metrics_q[$];
    logic        last_q[$];
    int          errors, sets_done, results_seen, records_sent;
    int          cycles;
    int          rx_wait;
    bit          hold_off;

    task automatic predict_record(input logic [7:0] id, input logic [15:0] arr,
                                  input logic [15:0] bur, input logic lst);
        int          pos;
        logic [20:0] fin, st, ct, tat, wt;
        logic [24:0] tsum, wsum;
        t_metrics    m;
        if (job_cnt < fsm_pkg::MaxJobs) begin
            pos = job_cnt;
            while (pos > 0 && job_arr[pos-1] > arr) begin
                job_id[pos] = job_id[pos-1];
                job_arr[pos] = job_arr[pos-1];
                job_bur[pos] = job_bur[pos-1];
                pos--;
            end
            job_id[pos] = id;
            job_arr[pos] = arr;
            job_bur[pos] = bur;
            job_cnt++;
        end
        if (!lst) return;
        fin = 0; tsum = 0; wsum = 0;
        for (int k = 0; k < job_cnt; k++) begin
            st  = (fin < 21'(job_arr[k])) ? 21'(job_arr[k]) : fin;
            ct  = st + 21'(job_bur[k]);
            tat = ct - 21'(job_arr[k]);
            wt  = tat - 21'(job_bur[k]);
            fin = ct;
            tsum += 25'(tat);
            wsum += 25'(wt);
            m = '0;
            m.id = job_id[k]; m.arrival = job_arr[k]; m.burst = job_bur[k];
            m.ct = ct; m.tat = tat; m.wt = wt;
            if (k == job_cnt - 1) begin
                m.avg_tat = 29'(({8'd0, tsum, 8'd0}) / job_cnt);
                m.avg_wt  = 29'(({8'd0, wsum, 8'd0}) / job_cnt);
            end
            metrics_q.push_back(m);
            last_q.push_back(k == job_cnt - 1);
        end
        job_cnt = 0;
    endtask

    task automatic send_record(input logic [7:0] id, input logic [15:0] arr,
                               input logic [15:0] bur, input logic lst);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bur, arr, id};
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_record(id, arr, bur, lst);
        records_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (metrics_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_random_set(input int n, input int span);
        for (int i = 0; i < n; i++)
            send_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, span)),
                        16'($urandom_range(0, span)), i == n - 1);
    endtask

    // directed: field extremes, single job, equal arrivals, idle gaps, full store
    task automatic test_directed();
        send_record(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_record(8'h00, 16'h0000, 16'h0000, 1'b1);
        send_record(8'h01, 16'd50, 16'd10, 1'b0);
        send_record(8'h02, 16'd50, 16'd5, 1'b0);
        send_record(8'h03, 16'd10, 16'd3, 1'b0);
        send_record(8'h04, 16'd500, 16'd1, 1'b1);
        for (int i = 0; i < 18; i++)
            send_record(8'(8'hA0 + i), 16'hFFFF - 16'(i * 7), 16'hFFFF, i == 17);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int n, r;
        while (records_sent < 350) begin
            r = $urandom_range(0, 9);
            n = (r < 6) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(7, 16)
                : $urandom_range(17, 20);
            send_random_set(n, ($urandom_range(0, 1) != 0) ? 65535 : 40);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        send_random_set(16, 65535);
        send_random_set(3, 100);
        send_random_set(2, 100);
        wait_drained();
    endtask

    // receiver draws an idle count per transfer, long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_wait = $urandom_range(0, 5);
            m_axis_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= (rx_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_metrics got, exp_m;
        logic     exp_last;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_metrics'(m_axis_tdata[160:0]);
            results_seen++;
            if (metrics_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
            end else begin
                exp_m = metrics_q.pop_front();
                exp_last = last_q.pop_front();
                if (got.id !== exp_m.id) begin
                    $display("%0t: id expected %0d actual %0d", $time, exp_m.id, got.id);
                    errors++;
                end
                if (got.arrival !== exp_m.arrival) begin
                    $display("%0t: arrival expected %0d actual %0d", $time,
                             exp_m.arrival, got.arrival);
                    errors++;
                end
                if (got.burst !== exp_m.burst) begin
                    $display("%0t: burst expected %0d actual %0d", $time,
                             exp_m.burst, got.burst);
                    errors++;
                end
                if (got.ct !== exp_m.ct) begin
                    $display("%0t: completion expected %0d actual %0d", $time,
                             exp_m.ct, got.ct);
                    errors++;
                end
                if (got.tat !== exp_m.tat) begin
                    $display("%0t: turnaround expected %0d actual %0d", $time,
                             exp_m.tat, got.tat);
                    errors++;
                end
                if (got.wt !== exp_m.wt) begin
                    $display("%0t: waiting expected %0d actual %0d", $time,
                             exp_m.wt, got.wt);
                    errors++;
                end
                if (got.avg_tat !== exp_m.avg_tat) begin
                    $display("%0t: avg turnaround expected %0d actual %0d", $time,
                             exp_m.avg_tat, got.avg_tat);
                    errors++;
                end
                if (got.avg_wt !== exp_m.avg_wt) begin
                    $display("%0t: avg waiting expected %0d actual %0d", $time,
                             exp_m.avg_wt, got.avg_wt);
                    errors++;
                end
                if (m_axis_tlast !== exp_last) begin
                    $display("%0t: tlast expected %0b actual %0b", $time,
                             exp_last, m_axis_tlast);
                    errors++;
                end
                if (exp_last) sets_done++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        job_cnt = 0; errors = 0; sets_done = 0; results_seen = 0;
        records_sent = 0; cycles = 0; hold_off = 1'b0; rx_wait = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_sets();
        $display("%0d records in %0d sets gave %0d checked results", records_sent,
                 sets_done, results_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
